@@ src/ctli_pkg.sv @@
// Shared types, widths and codes of the cyclic interpolation table.
package ctli_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int REQ_W   = 2;
	localparam int TIME_W  = 48;
	localparam int LOADV_W = 17;
	localparam int FRAC_W  = 16;
	localparam int STAT_W  = 2;
	localparam int CYCLE_W = 25;

	localparam logic [CYCLE_W-1:0] CYCLE_RST = 25'd22118400;
	localparam logic [FRAC_W-1:0]  FRAC_ONE  = 16'd32768;

	// Shared divider: 48-bit dividend, 26-bit divisor.
	localparam int DIV_W  = 48;
	localparam int DSR_W  = 26;
	// Interpolation operands.
	localparam int NUM_W  = 27;
	localparam int DIFF_W = 17;
	localparam int PROD_W = 44;
	localparam int QCL_W  = 17;
	localparam int VAL_W  = 19;

	typedef logic [REQ_W-1:0]  req_type_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam req_type_t REQ_LOAD  = 2'd0;
	localparam req_type_t REQ_QUERY = 2'd1;
	localparam req_type_t REQ_CLEAR = 2'd2;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_EMPTY = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;
	localparam status_t STAT_RANGE = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [CYCLE_W-1:0] t;
		logic [FRAC_W-1:0]  f;
	} sample_t;

endpackage

@@ src/ctli_if.sv @@
// Request and response channel interfaces of the cyclic interpolation table.
interface ctli_req_if;
	import ctli_pkg::*;
	logic                       valid;
	logic                       ready;
	req_type_t                  req_type;
	logic signed [TIME_W-1:0]   time_value;
	logic signed [LOADV_W-1:0]  load_value;

	modport source (output valid, output req_type, output time_value, output load_value,
		input ready);
	modport sink (input valid, input req_type, input time_value, input load_value,
		output ready);
endinterface

interface ctli_rsp_if;
	import ctli_pkg::*;
	logic              valid;
	logic              ready;
	logic [FRAC_W-1:0] fraction;
	status_t           status;

	modport source (output valid, output fraction, output status, input ready);
	modport sink (input valid, input fraction, input status, output ready);
endinterface

@@ src/ctli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ctli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/ctli_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module ctli_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ctli_pkg::DIV_W-1:0] dividend,
	input  logic [ctli_pkg::DSR_W-1:0] divisor,
	output ctli_pkg::div_stat_t        stat,
	output logic [ctli_pkg::DIV_W-1:0] quotient,
	output logic [ctli_pkg::DSR_W-1:0] remainder
);
	import ctli_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W+1:0] trial;

	// Trial subtract of the divisor from the shifted partial remainder.
	assign trial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[DSR_W+1]) begin
				rem_q <= trial[DSR_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DSR_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

@@ src/cyclic_table_linear_interp_unit.sv @@
// Top level of the cyclic piecewise-linear interpolation table.
//
// Channels: req carries items (req_type, time_value, load_value) in; rsp
// carries one result (fraction, status) out for every item, in order. Both
// use valid/ready and move an item at a clock edge with both high.
// cfg_we/cfg_wdata write the cycle length in ticks; write only while idle.
// A load, a clear, a reserved item or a query on an empty table goes from
// acceptance straight to ST_FIN and then into the output register. A query
// reduces its time modulo the cycle length in the shared 48-step divider,
// reads the first and last samples, scans one entry per cycle (at most
// TABLE_DEPTH-1 entries), multiplies once, then divides again in the same
// divider; when the bracketing times are equal, that second divide is
// skipped and the lower value is the result.
// One item is in work at a time; req.ready is high only while idle.
// The output register holds a finished result while rsp is stalled, and the
// next item may be accepted meanwhile; the sequencer then holds its result
// until the output register frees.
// Reset empties the table (the sample count drops to zero; the sample RAM
// is not swept), sets the cycle length to 24 hours and drops any pending
// result.
module cyclic_table_linear_interp_unit #(
	parameter int TABLE_DEPTH = ctli_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ctli_pkg::CYCLE_W-1:0] cfg_wdata,
	ctli_req_if.sink                     req,
	ctli_rsp_if.source                   rsp
);
	import ctli_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $bits(sample_t);
	localparam int ZX = NUM_W - CYCLE_W;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MOD  = 4'd1;
	localparam logic [3:0] ST_RDF  = 4'd2;
	localparam logic [3:0] ST_RDL  = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_SCAN = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_DST  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	logic [3:0]         state_q;
	logic [CYCLE_W-1:0] cycle_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;

	// Output register.
	logic              rsp_valid_q;
	logic [FRAC_W-1:0] rsp_frac_q;
	status_t           rsp_stat_q;
	logic              out_free;

	// Pending result held by the sequencer.
	logic [FRAC_W-1:0] res_frac_q;
	status_t           res_stat_q;

	// Query datapath.
	logic                     t_neg_q;
	logic [CYCLE_W-1:0]       r_q;
	logic [CYCLE_W-1:0]       tf_q, tl_q, prev_t_q;
	logic [FRAC_W-1:0]        ff_q, fl_q, prev_f_q;
	logic [FRAC_W-1:0]        lo_q, hi_q;
	logic signed [NUM_W-1:0]  num_q, den_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;

	// Memory and divider hookup.
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	sample_t       ram_wdata;
	sample_t       rd;
	logic [SW-1:0] ram_rdata;

	logic              div_start;
	logic [DIV_W-1:0]  div_dvd;
	logic [DSR_W-1:0]  div_dsr;
	div_stat_t         div_stat;
	logic [DIV_W-1:0]  div_quo;
	logic [DSR_W-1:0]  div_rem;

	logic                  acc;
	logic [CYCLE_W-1:0]    clen;
	logic [AW-1:0]         last_a;
	logic [TIME_W-1:0]     t_abs;
	logic                  ld_range_bad;
	logic                  ld_full;
	logic [FRAC_W-1:0]     ld_frac;
	logic [CYCLE_W-1:0]    r_d;
	logic [CYCLE_W-1:0]    rem_c;
	logic [PROD_W-1:0]     prod_abs;
	logic [NUM_W-1:0]      den_abs;
	logic signed [DIFF_W-1:0] diff_s;
	logic [QCL_W-1:0]      q_clip;
	logic signed [VAL_W-1:0] lo_x, q_x, v_s;
	logic [FRAC_W-1:0]     sat_frac;
	logic signed [NUM_W-1:0] r_x, tf_x, tl_x, c_x, prev_x, cur_x, rdt_x;
	logic                  scan_hit;

	assign acc      = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !rsp_valid_q || rsp.ready;

	// A zero cycle length behaves as one tick.
	assign clen   = (cycle_q == '0) ? CYCLE_W'(1) : cycle_q;
	assign last_a = AW'(cnt_q - CW'(1));

	// Load checks and clamp.
	assign ld_range_bad = req.time_value[TIME_W-1] ||
		($unsigned(req.time_value) >= TIME_W'(clen));
	assign ld_full = (cnt_q >= CW'(TABLE_DEPTH));
	always_comb begin
		if (req.load_value[LOADV_W-1]) begin
			ld_frac = '0;
		end else if (req.load_value[FRAC_W-1:0] > FRAC_ONE) begin
			ld_frac = FRAC_ONE;
		end else begin
			ld_frac = req.load_value[FRAC_W-1:0];
		end
	end

	assign ram_we      = acc && (req.req_type == REQ_LOAD) && !ld_range_bad && !ld_full;
	assign ram_wdata.t = req.time_value[CYCLE_W-1:0];
	assign ram_wdata.f = ld_frac;
	assign rd          = sample_t'(ram_rdata);

	// Read address: first entry, last entry, then walk upward from entry one.
	always_comb begin
		unique case (state_q)
			ST_RDF:  ram_raddr = '0;
			ST_RDL:  ram_raddr = last_a;
			ST_CHK:  ram_raddr = AW'(1);
			ST_SCAN: ram_raddr = idx_q + AW'(1);
			default: ram_raddr = '0;
		endcase
	end

	ctli_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divider operands: time magnitude by cycle length, or product by span.
	assign t_abs    = req.time_value[TIME_W-1] ? (~req.time_value + 1'b1) : req.time_value;
	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign den_abs  = den_q[NUM_W-1] ? NUM_W'(-den_q) : NUM_W'(den_q);
	assign div_start = (acc && (req.req_type == REQ_QUERY) && (cnt_q != '0)) ||
		((state_q == ST_DST) && (den_q != '0));
	assign div_dvd = (state_q == ST_IDLE) ? t_abs : DIV_W'(prod_abs);
	assign div_dsr = (state_q == ST_IDLE) ? DSR_W'(clen) : den_abs[DSR_W-1:0];

	ctli_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Non-negative remainder of the query time.
	assign rem_c = div_rem[CYCLE_W-1:0];
	assign r_d   = (t_neg_q && (rem_c != '0)) ? (clen - rem_c) : rem_c;

	// Signed views for the bracket arithmetic.
	assign r_x    = {{ZX{1'b0}}, r_q};
	assign tf_x   = {{ZX{1'b0}}, tf_q};
	assign tl_x   = {{ZX{1'b0}}, tl_q};
	assign c_x    = {{ZX{1'b0}}, clen};
	assign prev_x = {{ZX{1'b0}}, prev_t_q};
	assign cur_x  = {{ZX{1'b0}}, rd.t};
	assign rdt_x  = {{ZX{1'b0}}, rd.t};
	assign scan_hit = (prev_t_q <= r_q) && (r_q <= rd.t);

	assign diff_s = {1'b0, hi_q} - {1'b0, lo_q};

	// Apply the quotient to the lower value and saturate to [0, 1.0].
	assign q_clip = (div_quo[DIV_W-1:QCL_W] != '0) ? '1 : div_quo[QCL_W-1:0];
	assign lo_x   = {{(VAL_W-FRAC_W){1'b0}}, lo_q};
	assign q_x    = {{(VAL_W-QCL_W){1'b0}}, q_clip};
	assign v_s    = neg_q ? (lo_x - q_x) : (lo_x + q_x);
	always_comb begin
		if (v_s < 0) begin
			sat_frac = '0;
		end else if (v_s > VAL_W'(FRAC_ONE)) begin
			sat_frac = FRAC_ONE;
		end else begin
			sat_frac = v_s[FRAC_W-1:0];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cycle_q     <= CYCLE_RST;
			cnt_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cycle_q <= cfg_wdata;
			end

			if ((state_q == ST_FIN) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req.req_type)
							REQ_LOAD: begin
								if (ram_we) begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= ST_FIN;
							end
							REQ_QUERY: begin
								state_q <= (cnt_q == '0) ? ST_FIN : ST_MOD;
							end
							REQ_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_MOD: begin
					if (div_stat.done) begin
						state_q <= ST_RDF;
					end
				end
				ST_RDF: state_q <= ST_RDL;
				ST_RDL: state_q <= ST_CHK;
				ST_CHK: begin
					idx_q <= AW'(1);
					if ((r_q >= rd.t) || (r_q < tf_q)) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_hit || (idx_q == last_a)) begin
						state_q <= ST_MUL;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_MUL: state_q <= ST_DST;
				ST_DST: begin
					state_q <= (den_q == '0) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			rsp_frac_q <= res_frac_q;
			rsp_stat_q <= res_stat_q;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					t_neg_q    <= req.time_value[TIME_W-1];
					res_frac_q <= '0;
					unique case (req.req_type)
						REQ_LOAD: begin
							if (ld_range_bad) begin
								res_stat_q <= STAT_RANGE;
							end else if (ld_full) begin
								res_stat_q <= STAT_FULL;
							end else begin
								res_stat_q <= STAT_OK;
							end
						end
						REQ_QUERY: begin
							res_stat_q <= (cnt_q == '0) ? STAT_EMPTY : STAT_OK;
						end
						default: begin
							res_stat_q <= STAT_OK;
						end
					endcase
				end
			end
			ST_MOD: begin
				if (div_stat.done) begin
					r_q <= r_d;
				end
			end
			ST_RDL: begin
				tf_q <= rd.t;
				ff_q <= rd.f;
			end
			ST_CHK: begin
				tl_q     <= rd.t;
				fl_q     <= rd.f;
				prev_t_q <= tf_q;
				prev_f_q <= ff_q;
				// Wrap pair (last, first + cycle) or (last - cycle, first).
				lo_q  <= rd.f;
				hi_q  <= ff_q;
				den_q <= c_x + tf_x - rdt_x;
				if (r_q >= rd.t) begin
					num_q <= r_x - rdt_x;
				end else begin
					num_q <= r_x - rdt_x + c_x;
				end
			end
			ST_SCAN: begin
				priority if (scan_hit) begin
					num_q <= r_x - prev_x;
					den_q <= cur_x - prev_x;
					lo_q  <= prev_f_q;
					hi_q  <= rd.f;
				end else if (idx_q == last_a) begin
					// No bracket in an unordered table: use first and last.
					num_q <= r_x - tf_x;
					den_q <= tl_x - tf_x;
					lo_q  <= ff_q;
					hi_q  <= fl_q;
				end else begin
					prev_t_q <= rd.t;
					prev_f_q <= rd.f;
				end
			end
			ST_MUL: begin
				prod_q <= num_q * diff_s;
			end
			ST_DST: begin
				neg_q <= prod_q[PROD_W-1] ^ den_q[NUM_W-1];
				if (den_q == '0) begin
					res_frac_q <= lo_q;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					res_frac_q <= sat_frac;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.fraction = rsp_frac_q;
	assign rsp.status   = rsp_stat_q;
endmodule

@@ src/ctli_checker.sv @@
// Port-level checker of the cyclic interpolation table and its bind.
module ctli_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ctli_pkg::FRAC_W-1:0] fraction,
	input ctli_pkg::status_t           status
);
	import ctli_pkg::*;

	// Hold a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(fraction) && $stable(status))
		else $error("stalled result changed");

	// Drop ready for the cycle after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after an item");

	// Zero fraction on every error status.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |-> fraction == '0)
		else $error("nonzero fraction with error status");

	// Keep the fraction within one.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fraction <= FRAC_ONE)
		else $error("fraction above one");
endmodule

bind cyclic_table_linear_interp_unit ctli_checker u_ctli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.fraction  (rsp.fraction),
	.status    (rsp.status)
);
